// ----- hdl/cgbb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgbb_pkg - shared types and constants of the glyph blitter
// Action and coverage codes, register indexes, the configuration record and
// the records that pass between the pipeline stages.
// ----------------------------------------------------------------------------
package cgbb_pkg;

	localparam int TABLE_ENTRIES = 65536;
	localparam int TABLE_AW = $clog2(TABLE_ENTRIES);

	// Register file: seven registers at word addresses.
	localparam int REG_AW = 5;
	localparam logic [2:0] REG_CLIP_LEFT      = 3'd0;
	localparam logic [2:0] REG_CLIP_TOP       = 3'd1;
	localparam logic [2:0] REG_CLIP_RIGHT     = 3'd2;
	localparam logic [2:0] REG_CLIP_BOTTOM    = 3'd3;
	localparam logic [2:0] REG_DRAW_COLOR     = 3'd4;
	localparam logic [2:0] REG_SURFACE_STRIDE = 3'd5;
	localparam logic [2:0] REG_CLIPPING_ON    = 3'd6;

	localparam logic [1:0] ACT_SETUP = 2'd0;
	localparam logic [1:0] ACT_PIXEL = 2'd1;
	localparam logic [1:0] ACT_LOAD  = 2'd2;

	localparam logic [7:0] COV_CLEAR    = 8'h00;
	localparam logic [7:0] COV_BLEND_CD = 8'h01;
	localparam logic [7:0] COV_BLEND_DC = 8'h02;
	localparam logic [7:0] COV_INK      = 8'hff;

	typedef struct packed {
		logic signed [15:0] clip_left;
		logic signed [15:0] clip_top;
		logic signed [15:0] clip_right;
		logic signed [15:0] clip_bottom;
		logic [7:0]         draw_color;
		logic [12:0]        surface_stride;
		logic               clipping_on;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [15:0] cursor_x;
		logic signed [15:0] cursor_y;
		logic signed [7:0]  glyph_x_offset;
		logic signed [7:0]  glyph_y_offset;
		logic [11:0]        glyph_width;
		logic [11:0]        glyph_height;
		logic signed [7:0]  glyph_advance;
		logic [7:0]         src_byte;
		logic [7:0]         dst_byte;
		logic [15:0]        table_index;
		logic [7:0]         table_value;
	} item_t;

	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic tbl_wr;
	} pipe_ctl_t;

	typedef struct packed {
		logic               visible;
		logic [23:0]        src_skip;
		logic [26:0]        dest_offset;
		logic [11:0]        draw_width;
		logic [11:0]        draw_height;
		logic [11:0]        src_row_skip;
		logic signed [15:0] new_cursor_x;
	} geom_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       write_enable;
	} pix_t;

endpackage

// ----- hdl/clipped_glyph_blit_blend.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_glyph_blit_blend - clipped glyph blitter and 8-bit pixel blender
// Top level: input stage, stage handshake, output register and the APB port.
// ----------------------------------------------------------------------------
// The block takes one word per clock while item_stall is low and returns one
// result word for each, in order. A setup word trims a glyph box against the
// clip rectangle when clipping is on and returns its source and surface
// offsets; a pixel word blends one coverage byte with one destination byte
// through the draw color and the 256 by 256 blend table; a load word writes
// one table entry. The rate is one word per cycle while no stage holds, and
// is set by the five-stage pipeline: input register, table read with the top
// and left trims, bottom and right trims, the offset multipliers, and the
// output register. Each stage holds only while the stage after it is full and
// stalled, so words keep entering while a finished result waits. A pixel
// read sees every table load accepted before it. The table is never cleared:
// an entry reads as undefined until a load word writes it. The user must write
// configuration registers over the APB port only while no word is in flight;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module clipped_glyph_blit_blend (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cgbb_pkg::REG_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// input words
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [1:0]                  action,
	input  logic signed [15:0]          cursor_x,
	input  logic signed [15:0]          cursor_y,
	input  logic signed [7:0]           glyph_x_offset,
	input  logic signed [7:0]           glyph_y_offset,
	input  logic [11:0]                 glyph_width,
	input  logic [11:0]                 glyph_height,
	input  logic signed [7:0]           glyph_advance,
	input  logic [7:0]                  src_byte,
	input  logic [7:0]                  dst_byte,
	input  logic [15:0]                 table_index,
	input  logic [7:0]                  table_value,
	// result words
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic                        visible,
	output logic [23:0]                 src_skip,
	output logic [26:0]                 dest_offset,
	output logic [11:0]                 draw_width,
	output logic [11:0]                 draw_height,
	output logic [11:0]                 src_row_skip,
	output logic signed [15:0]          new_cursor_x,
	output logic [7:0]                  out_byte,
	output logic                        write_enable
);
	import cgbb_pkg::*;

	cfg_t      cfg;
	item_t     item_c, item_s1;
	pipe_ctl_t ctl;
	geom_t     geom_s4, geom_q;
	pix_t      pix_s3, pix_s4, pix_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy_out;

	cgbb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Gather the input fields into one word record.
	always_comb begin
		item_c.action         = action;
		item_c.cursor_x       = cursor_x;
		item_c.cursor_y       = cursor_y;
		item_c.glyph_x_offset = glyph_x_offset;
		item_c.glyph_y_offset = glyph_y_offset;
		item_c.glyph_width    = glyph_width;
		item_c.glyph_height   = glyph_height;
		item_c.glyph_advance  = glyph_advance;
		item_c.src_byte       = src_byte;
		item_c.dst_byte       = dst_byte;
		item_c.table_index    = table_index;
		item_c.table_value    = table_value;
	end

	// A stage may load when it is empty or when the stage after it moves on.
	// This lets bubbles collapse, so a stalled result only backs up the
	// stages that actually hold words.
	assign rdy_out    = !out_valid_q || !result_stall;
	assign rdy4       = !valid_s4 || rdy_out;
	assign rdy3       = !valid_s3 || rdy4;
	assign rdy2       = !valid_s2 || rdy3;
	assign rdy1       = !valid_s1 || rdy2;
	assign item_stall = !rdy1;

	// The table write happens as a load word leaves the input stage, at the
	// same point where pixel words issue their reads, so order is kept.
	always_comb begin
		ctl.ld_s2  = rdy2;
		ctl.ld_s3  = rdy3;
		ctl.ld_s4  = rdy4;
		ctl.tbl_wr = rdy2 && valid_s1 && (item_s1.action == ACT_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= item_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
			if (rdy_out) begin
				out_valid_q <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			item_s1 <= item_c;
		end
		if (rdy4) begin
			pix_s4 <= pix_s3;
		end
		if (rdy_out) begin
			geom_q <= geom_s4;
			pix_q  <= pix_s4;
		end
	end

	cgbb_geom u_geom (
		.clk     (clk),
		.item_s1 (item_s1),
		.cfg     (cfg),
		.ctl     (ctl),
		.geom_s4 (geom_s4)
	);

	cgbb_blend u_blend (
		.clk        (clk),
		.item_s1    (item_s1),
		.draw_color (cfg.draw_color),
		.ctl        (ctl),
		.pix_s3     (pix_s3)
	);

	// The output register drives the result ports directly.
	assign result_valid = out_valid_q;
	assign visible      = geom_q.visible;
	assign src_skip     = geom_q.src_skip;
	assign dest_offset  = geom_q.dest_offset;
	assign draw_width   = geom_q.draw_width;
	assign draw_height  = geom_q.draw_height;
	assign src_row_skip = geom_q.src_row_skip;
	assign new_cursor_x = geom_q.new_cursor_x;
	assign out_byte     = pix_q.out_byte;
	assign write_enable = pix_q.write_enable;

endmodule

// ----- hdl/cgbb_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgbb_regs - configuration register file
// APB-style slave holding the clip rectangle, ink color, stride and mode.
// ----------------------------------------------------------------------------
module cgbb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cgbb_pkg::REG_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output cgbb_pkg::cfg_t              cfg
);
	import cgbb_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr;

	assign reg_idx = paddr[REG_AW-1:2];
	assign wr      = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clip_left      <= '0;
			cfg_q.clip_top       <= '0;
			cfg_q.clip_right     <= '0;
			cfg_q.clip_bottom    <= '0;
			cfg_q.draw_color     <= '0;
			cfg_q.surface_stride <= '0;
			cfg_q.clipping_on    <= 1'b1;
		end else if (wr) begin
			unique case (reg_idx)
				REG_CLIP_LEFT:      cfg_q.clip_left      <= pwdata[15:0];
				REG_CLIP_TOP:       cfg_q.clip_top       <= pwdata[15:0];
				REG_CLIP_RIGHT:     cfg_q.clip_right     <= pwdata[15:0];
				REG_CLIP_BOTTOM:    cfg_q.clip_bottom    <= pwdata[15:0];
				REG_DRAW_COLOR:     cfg_q.draw_color     <= pwdata[7:0];
				REG_SURFACE_STRIDE: cfg_q.surface_stride <= pwdata[12:0];
				REG_CLIPPING_ON:    cfg_q.clipping_on    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_CLIP_LEFT:      prdata = {16'd0, cfg_q.clip_left};
			REG_CLIP_TOP:       prdata = {16'd0, cfg_q.clip_top};
			REG_CLIP_RIGHT:     prdata = {16'd0, cfg_q.clip_right};
			REG_CLIP_BOTTOM:    prdata = {16'd0, cfg_q.clip_bottom};
			REG_DRAW_COLOR:     prdata = {24'd0, cfg_q.draw_color};
			REG_SURFACE_STRIDE: prdata = {19'd0, cfg_q.surface_stride};
			REG_CLIPPING_ON:    prdata = {31'd0, cfg_q.clipping_on};
			default:            prdata = '0;
		endcase
	end

endmodule

// ----- hdl/cgbb_geom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgbb_geom - glyph setup pipeline
// Trims the glyph box against the clip rectangle over two stages, then forms
// the source and surface offsets with one multiply stage and a final add.
// ----------------------------------------------------------------------------
module cgbb_geom (
	input  logic                clk,
	input  cgbb_pkg::item_t     item_s1,
	input  cgbb_pkg::cfg_t      cfg,
	input  cgbb_pkg::pipe_ctl_t ctl,
	output cgbb_pkg::geom_t     geom_s4
);
	import cgbb_pkg::*;

	// Stage 2: top and left trims, unclipped origin, advanced pen.
	logic [15:0] top0, left0, ydiff, xdiff, ncx0, ncx_c;
	logic [15:0] dh1_c, dw1_c, top1_c, left1_c;
	logic [14:0] tskip_c, lskip_c;
	logic [16:0] ufy_c, ufx_c;
	logic        ytrim, xtrim;

	logic [1:0]  act_s2;
	logic        clip_s2;
	logic [11:0] w_s2, h_s2;
	logic [14:0] tskip_s2, lskip_s2;
	logic [15:0] dh1_s2, dw1_s2, top1_s2, left1_s2, ncx_s2;
	logic [16:0] ufy_s2, ufx_s2;

	always_comb begin
		top0  = item_s1.cursor_y + {{8{item_s1.glyph_y_offset[7]}}, item_s1.glyph_y_offset};
		left0 = item_s1.cursor_x + {{8{item_s1.glyph_x_offset[7]}}, item_s1.glyph_x_offset};
		ydiff = cfg.clip_top - top0;
		xdiff = cfg.clip_left - left0;
		ytrim = !ydiff[15] && (ydiff != 16'd0);
		xtrim = !xdiff[15] && (xdiff != 16'd0);
		tskip_c = ytrim ? ydiff[14:0] : 15'd0;
		lskip_c = xtrim ? xdiff[14:0] : 15'd0;
		dh1_c   = ytrim ? ({4'd0, item_s1.glyph_height} - ydiff) : {4'd0, item_s1.glyph_height};
		dw1_c   = xtrim ? ({4'd0, item_s1.glyph_width} - xdiff) : {4'd0, item_s1.glyph_width};
		top1_c  = ytrim ? cfg.clip_top : top0;
		left1_c = xtrim ? cfg.clip_left : left0;
		ufy_c = {item_s1.cursor_y[15], item_s1.cursor_y}
			+ {{9{item_s1.glyph_y_offset[7]}}, item_s1.glyph_y_offset};
		ufx_c = {item_s1.cursor_x[15], item_s1.cursor_x}
			+ {{9{item_s1.glyph_x_offset[7]}}, item_s1.glyph_x_offset};
		ncx0  = item_s1.cursor_x + {{8{item_s1.glyph_advance[7]}}, item_s1.glyph_advance};
		ncx_c = ncx0;
		if (cfg.clipping_on && ($signed(cfg.clip_right) < $signed(ncx0))) begin
			ncx_c = cfg.clip_right;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			act_s2   <= item_s1.action;
			clip_s2  <= cfg.clipping_on;
			w_s2     <= item_s1.glyph_width;
			h_s2     <= item_s1.glyph_height;
			tskip_s2 <= tskip_c;
			lskip_s2 <= lskip_c;
			dh1_s2   <= dh1_c;
			dw1_s2   <= dw1_c;
			top1_s2  <= top1_c;
			left1_s2 <= left1_c;
			ufy_s2   <= ufy_c;
			ufx_s2   <= ufx_c;
			ncx_s2   <= ncx_c;
		end
	end

	// Stage 3: bottom and right trims, visibility, multiplier operands.
	logic [15:0] yd2, xd2, dh2, dw2;
	logic        ybot, xrgt, vis_c;
	logic [11:0] dw_c, dh_c, rskip_c;
	logic [16:0] ymul_c, xadd_c;

	logic [1:0]  act_s3;
	logic        clip_s3, vis_s3;
	logic [11:0] dw_s3, dh_s3, rskip_s3, w_s3;
	logic [14:0] tskip_s3, lskip_s3;
	logic [16:0] ymul_s3, xadd_s3;
	logic [15:0] ncx_s3;

	always_comb begin
		yd2  = dh1_s2 - cfg.clip_bottom + top1_s2;
		xd2  = dw1_s2 - cfg.clip_right + left1_s2;
		ybot = !yd2[15] && (yd2 != 16'd0);
		xrgt = !xd2[15] && (xd2 != 16'd0);
		dh2  = ybot ? (dh1_s2 - yd2) : dh1_s2;
		dw2  = xrgt ? (dw1_s2 - xd2) : dw1_s2;
		if (clip_s2) begin
			vis_c   = !dh2[15] && (dh2 != 16'd0) && !dw2[15] && (dw2 != 16'd0);
			dw_c    = vis_c ? dw2[11:0] : 12'd0;
			dh_c    = vis_c ? dh2[11:0] : 12'd0;
			rskip_c = vis_c ? (w_s2 - dw2[11:0]) : 12'd0;
			ymul_c  = {top1_s2[15], top1_s2};
			xadd_c  = {left1_s2[15], left1_s2};
		end else begin
			vis_c   = (w_s2 != 12'd0) && (h_s2 != 12'd0);
			dw_c    = w_s2;
			dh_c    = h_s2;
			rskip_c = 12'd0;
			ymul_c  = ufy_s2;
			xadd_c  = ufx_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			act_s3   <= act_s2;
			clip_s3  <= clip_s2;
			vis_s3   <= vis_c;
			dw_s3    <= dw_c;
			dh_s3    <= dh_c;
			rskip_s3 <= rskip_c;
			w_s3     <= w_s2;
			tskip_s3 <= tskip_s2;
			lskip_s3 <= lskip_s2;
			ymul_s3  <= ymul_c;
			xadd_s3  <= xadd_c;
			ncx_s3   <= ncx_s2;
		end
	end

	// Stage 4: row origin times stride, and glyph width times top trim.
	logic signed [30:0] prody_c;
	logic [26:0]        prods_c;

	logic [1:0]  act_s4;
	logic        clip_s4, vis_s4;
	logic [11:0] dw_s4, dh_s4, rskip_s4;
	logic [14:0] lskip_s4;
	logic [16:0] xadd_s4;
	logic [15:0] ncx_s4;
	logic [26:0] prody_s4;
	logic [23:0] prods_s4;

	always_comb begin
		prody_c = $signed(ymul_s3) * $signed({1'b0, cfg.surface_stride});
		prods_c = w_s3 * tskip_s3;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			act_s4   <= act_s3;
			clip_s4  <= clip_s3;
			vis_s4   <= vis_s3;
			dw_s4    <= dw_s3;
			dh_s4    <= dh_s3;
			rskip_s4 <= rskip_s3;
			lskip_s4 <= lskip_s3;
			xadd_s4  <= xadd_s3;
			ncx_s4   <= ncx_s3;
			prody_s4 <= prody_c[26:0];
			prods_s4 <= prods_c[23:0];
		end
	end

	// Final adds and field selection feed the output register.
	logic [26:0] dest_c;
	logic [23:0] srcs_c;

	always_comb begin
		dest_c  = prody_s4 + {{10{xadd_s4[16]}}, xadd_s4};
		srcs_c  = prods_s4 + {9'd0, lskip_s4};
		geom_s4 = '0;
		if (act_s4 == ACT_SETUP) begin
			geom_s4.new_cursor_x = ncx_s4;
			if (!clip_s4 || vis_s4) begin
				geom_s4.visible      = vis_s4;
				geom_s4.src_skip     = clip_s4 ? srcs_c : 24'd0;
				geom_s4.dest_offset  = dest_c;
				geom_s4.draw_width   = dw_s4;
				geom_s4.draw_height  = dh_s4;
				geom_s4.src_row_skip = rskip_s4;
			end
		end
	end

endmodule

// ----- hdl/cgbb_blend.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgbb_blend - blend table and pixel blender
// Holds the 256 by 256 blend table with one write and one registered read
// port, and forms the blended pixel one stage after the table read.
// ----------------------------------------------------------------------------
module cgbb_blend (
	input  logic                clk,
	input  cgbb_pkg::item_t     item_s1,
	input  logic [7:0]          draw_color,
	input  cgbb_pkg::pipe_ctl_t ctl,
	output cgbb_pkg::pix_t      pix_s3
);
	import cgbb_pkg::*;

	logic [7:0] table_mem [TABLE_ENTRIES];

	logic [TABLE_AW-1:0] raddr, waddr;
	logic [7:0]          rd_s2, src_s2, dst_s2;
	logic                pixel_s2;
	pix_t                pix_c;

	// Coverage code 2 swaps the row and column of the lookup.
	always_comb begin
		if (item_s1.src_byte == COV_BLEND_DC) begin
			raddr = TABLE_AW'({item_s1.dst_byte, draw_color});
		end else begin
			raddr = TABLE_AW'({draw_color, item_s1.dst_byte});
		end
		waddr = item_s1.table_index[TABLE_AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.tbl_wr) begin
			table_mem[waddr] <= item_s1.table_value;
		end
		if (ctl.ld_s2) begin
			rd_s2 <= table_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			pixel_s2 <= (item_s1.action == ACT_PIXEL);
			src_s2   <= item_s1.src_byte;
			dst_s2   <= item_s1.dst_byte;
		end
	end

	always_comb begin
		pix_c = '0;
		if (pixel_s2) begin
			pix_c.write_enable = 1'b1;
			unique case (src_s2)
				COV_CLEAR: begin
					pix_c.out_byte     = dst_s2;
					pix_c.write_enable = 1'b0;
				end
				COV_INK:      pix_c.out_byte = draw_color;
				COV_BLEND_CD: pix_c.out_byte = rd_s2;
				COV_BLEND_DC: pix_c.out_byte = rd_s2;
				default:      pix_c.out_byte = src_s2;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			pix_s3 <= pix_c;
		end
	end

endmodule

// ----- hdl/cgbb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgbb_checker - port-level checks of the glyph blitter
// Watches the top-level ports only and is bound to the top level.
// ----------------------------------------------------------------------------
module cgbb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        item_stall,
	input logic                        result_valid,
	input logic                        result_stall,
	input logic                        visible,
	input logic [23:0]                 src_skip,
	input logic [26:0]                 dest_offset,
	input logic [11:0]                 draw_width,
	input logic [11:0]                 draw_height,
	input logic [11:0]                 src_row_skip,
	input logic signed [15:0]          new_cursor_x,
	input logic [7:0]                  out_byte,
	input logic                        write_enable
);

	// A waiting result is not withdrawn.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	// With the output register empty the whole pipeline can move.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("input stalled while no result is waiting");

	// A pixel write carries no glyph geometry.
	a_pixel_no_geom: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && write_enable |->
			!visible && (draw_width == 12'd0) && (draw_height == 12'd0)
			&& (new_cursor_x == 16'sd0) && (dest_offset == 27'd0))
		else $error("pixel result carries geometry");

	// A hidden glyph skips no source bytes; a visible one writes no pixel.
	a_skip_needs_visible: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			(visible || ((src_skip == 24'd0) && (src_row_skip == 12'd0)))
			&& (!visible || (!write_enable && (out_byte == 8'd0))))
		else $error("source skip without visible glyph");

endmodule

bind clipped_glyph_blit_blend cgbb_checker u_checker (.*);
